### rtl/q_learning_slot_aloha_mac_assert.svh
// Assertion macros shared by the RTL of the slotted ALOHA MAC.
// Both macros expect clk_i in the scope where they are used; QLSA_ASSERT also expects rst_ni.
`ifndef Q_LEARNING_SLOT_ALOHA_MAC_ASSERT_SVH
`define Q_LEARNING_SLOT_ALOHA_MAC_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define QLSA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
// Checked on every rising edge, reset included.
`define QLSA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);
`else
`define QLSA_ASSERT(lbl, prop, msg)
`define QLSA_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### rtl/qlsa_pkg.sv
`default_nettype none

package qlsa_pkg;

  // Request codes.
  localparam logic [2:0] REQ_ENQ      = 3'd0;
  localparam logic [2:0] REQ_TICK     = 3'd1;
  localparam logic [2:0] REQ_TX_END   = 3'd2;
  localparam logic [2:0] REQ_RX_START = 3'd3;
  localparam logic [2:0] REQ_RX_END   = 3'd4;

  // Drop codes.
  localparam logic [2:0] DROP_NONE       = 3'd0;
  localparam logic [2:0] DROP_QUEUE_FULL = 3'd1;
  localparam logic [2:0] DROP_CORRUPT    = 3'd2;
  localparam logic [2:0] DROP_NOT_MINE   = 3'd3;
  localparam logic [2:0] DROP_NOT_ACK    = 3'd4;
  localparam logic [2:0] DROP_BUSY       = 3'd5;
  localparam logic [2:0] DROP_ACK_OUT    = 3'd6;

  // Radio states.
  localparam logic [1:0] RADIO_IDLE     = 2'd0;
  localparam logic [1:0] RADIO_TX       = 2'd1;
  localparam logic [1:0] RADIO_WAIT_ACK = 2'd2;
  localparam logic [1:0] RADIO_RX       = 2'd3;

  // Backoff modes.
  localparam logic [1:0] BO_NEVER    = 2'd0;
  localparam logic [1:0] BO_ALWAYS   = 2'd1;
  localparam logic [1:0] BO_NOT_BEST = 2'd2;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SLOTS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_PER_SLOT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BACKOFF_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_LIMIT  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ADDR    = 3'd4;

  // Q format: 14 fraction bits, learning rate 1638/16384.
  localparam int Q_ONE   = 16384;
  localparam int Q_ALPHA = 1638;
  localparam int Q_FRAC  = 14;

  typedef struct packed {
    logic [2:0]  req_type;
    logic        rx_error;
    logic [7:0]  rx_dest_addr;
    logic        rx_is_ack;
    logic [15:0] rand_value;
  } evt_t;

  typedef struct packed {
    logic       tx_start;
    logic [2:0] drop_code;
    logic       add_backoff;
    logic [3:0] current_slot;
    logic [3:0] chosen_slot;
    logic       slot_mine;
    logic [6:0] queue_count;
    logic       ack_taken;
  } res_t;

  // Control of the table scan unit.
  typedef struct packed {
    logic start;
    logic find;
  } scan_cmd_t;

  typedef struct packed {
    logic done;
    logic hit;
  } scan_sts_t;

endpackage

`default_nettype wire

### rtl/qlsa_stream_if.sv
`default_nettype none

interface qlsa_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

### rtl/q_learning_slot_aloha_mac.sv
// Channel   Direction  Payload             Role
// evt_i     in         qlsa_pkg::evt_t     MAC events: enqueue, slot tick, tx/rx edges
// res_o     out        qlsa_pkg::res_t     one status result per event
// cfg_*     in         index + 8-bit data  register writes, no read-back
//
// Enqueue, tx end, rx start, rx end and unknown requests go straight to the done state.
// An accepted ack adds the Q update (read, multiply, write).
// A slot tick advances the slot, plus a missed-slot penalty, plus the best-slot
// scan in backoff mode 2 after that penalty, plus two scans at frame wrap; the
// scans read one Q entry per cycle, up to the effective slot count, through the
// single table read port.
// Reset is asynchronous and clears the Q table at once through per-entry valid bits.
// A new event is taken while the previous result still waits in the output register.
`default_nettype none
`include "q_learning_slot_aloha_mac_assert.svh"

module q_learning_slot_aloha_mac #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned QUEUE_MAX = 64,
  parameter int unsigned Q_BITS    = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  qlsa_stream_if.sink                              evt_i,
  qlsa_stream_if.source                            res_o,
  input  wire logic                                cfg_we_i,
  input  wire logic [qlsa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  wire logic [qlsa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);

  // Slot numbers carry one extra bit so that the slot count itself fits.
  localparam int unsigned SW = $clog2(SLOTS + 1);
  localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned QW = $clog2(QUEUE_MAX + 1);
  localparam int unsigned CW = (SW > 5) ? SW : 5;
  localparam int unsigned LW = (QW > 7) ? QW : 7;
  localparam int unsigned TW = 16 + SW;

  // Sequencer states.
  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UPD_RD   = 4'd1;
  localparam logic [3:0] S_UPD_MUL  = 4'd2;
  localparam logic [3:0] S_UPD_WR   = 4'd3;
  localparam logic [3:0] S_BO_GO    = 4'd4;
  localparam logic [3:0] S_BO_WAIT  = 4'd5;
  localparam logic [3:0] S_ADV      = 4'd6;
  localparam logic [3:0] S_PK1_GO   = 4'd7;
  localparam logic [3:0] S_PK1_WAIT = 4'd8;
  localparam logic [3:0] S_PK_IDX   = 4'd9;
  localparam logic [3:0] S_PK2_GO   = 4'd10;
  localparam logic [3:0] S_PK2_WAIT = 4'd11;
  localparam logic [3:0] S_OWN      = 4'd12;
  localparam logic [3:0] S_DONE     = 4'd13;

  // Configuration registers.
  logic [4:0] num_slots_q;
  logic [7:0] max_per_slot_q;
  logic [1:0] backoff_mode_q;
  logic [6:0] queue_limit_q;
  logic [7:0] node_addr_q;

  // Sequencer and MAC state.
  logic [3:0]      state_q, state_d;
  qlsa_pkg::evt_t  ev_q, ev_d;
  logic [SW-1:0]   slot_idx_q, slot_idx_d;
  logic [SW-1:0]   own_slot_q, own_slot_d;
  logic            in_own_q, in_own_d;
  logic [1:0]      radio_q, radio_d;
  logic            ack_seen_q, ack_seen_d;
  logic            sent_frame_q, sent_frame_d;
  logic [QW-1:0]   waiting_q, waiting_d;
  logic [SW-1:0]   idx_q, idx_d;

  // Result fields gathered while the event is worked on.
  logic            pend_tx_q, pend_tx_d;
  logic [2:0]      pend_drop_q, pend_drop_d;
  logic            pend_boff_q, pend_boff_d;
  logic            pend_taken_q, pend_taken_d;

  // Output register.
  qlsa_pkg::res_t  res_q, res_next;
  logic            res_vld_q;
  logic            res_load;

  // Datapath connections.
  logic                     qt_upd_rd, qt_rd_en, qt_wr_en;
  logic [AW-1:0]            qt_rd_addr;
  logic signed [Q_BITS-1:0] qt_rdata, q_new;
  logic                     upd_mul;
  qlsa_pkg::scan_cmd_t      scan_cmd;
  qlsa_pkg::scan_sts_t      scan_sts;
  logic                     scan_rd_en;
  logic [AW-1:0]            scan_addr;
  logic signed [Q_BITS-1:0] scan_max;
  logic [SW-1:0]            scan_ties, scan_pos;

  // Derived values.
  logic [CW-1:0] ns_ext, slot_ext, own_ext;
  logic [SW-1:0] n_eff, slot_inc;
  logic [LW-1:0] lim_ext, wait_ext;
  logic [TW-1:0] tie_prod;
  logic          own_match;

  // The slot count in use is the register clamped to 1..SLOTS.
  always_comb begin
    ns_ext = CW'(num_slots_q);
    if (ns_ext == '0) begin
      n_eff = SW'(1);
    end else if (ns_ext > CW'(SLOTS)) begin
      n_eff = SW'(SLOTS);
    end else begin
      n_eff = ns_ext[SW-1:0];
    end
  end

  // The queue limit in use never exceeds the queue depth.
  assign wait_ext = LW'(waiting_q);
  assign lim_ext  = (LW'(queue_limit_q) > LW'(QUEUE_MAX)) ? LW'(QUEUE_MAX)
                                                          : LW'(queue_limit_q);

  assign slot_inc  = slot_idx_q + SW'(1);
  assign own_match = (own_slot_q == slot_idx_q);
  assign slot_ext  = CW'(slot_idx_q);
  assign own_ext   = CW'(own_slot_q);

  // Tie index: the random word scales the tie count into 0..ties-1.
  assign tie_prod = TW'(ev_q.rand_value) * TW'(scan_ties);

  // Configuration writes; indexes past the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_slots_q    <= 5'd1;
      max_per_slot_q <= 8'd1;
      backoff_mode_q <= qlsa_pkg::BO_NEVER;
      queue_limit_q  <= 7'd16;
      node_addr_q    <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        qlsa_pkg::CFG_NUM_SLOTS:    num_slots_q    <= cfg_wdata_i[4:0];
        qlsa_pkg::CFG_MAX_PER_SLOT: max_per_slot_q <= cfg_wdata_i;
        qlsa_pkg::CFG_BACKOFF_MODE: backoff_mode_q <= cfg_wdata_i[1:0];
        qlsa_pkg::CFG_QUEUE_LIMIT:  queue_limit_q  <= cfg_wdata_i[6:0];
        qlsa_pkg::CFG_NODE_ADDR:    node_addr_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Sequencer. Simple events go straight to the done state; a tick or an
  // accepted ack walks through the update, the scans and the slot advance.
  always_comb begin
    state_d      = state_q;
    ev_d         = ev_q;
    slot_idx_d   = slot_idx_q;
    own_slot_d   = own_slot_q;
    in_own_d     = in_own_q;
    radio_d      = radio_q;
    ack_seen_d   = ack_seen_q;
    sent_frame_d = sent_frame_q;
    waiting_d    = waiting_q;
    idx_d        = idx_q;
    pend_tx_d    = pend_tx_q;
    pend_drop_d  = pend_drop_q;
    pend_boff_d  = pend_boff_q;
    pend_taken_d = pend_taken_q;
    qt_upd_rd    = 1'b0;
    qt_wr_en     = 1'b0;
    upd_mul      = 1'b0;
    scan_cmd     = '0;

    unique case (state_q)
      S_IDLE: begin
        if (evt_i.valid) begin
          ev_d         = evt_i.payload;
          pend_tx_d    = 1'b0;
          pend_drop_d  = qlsa_pkg::DROP_NONE;
          pend_boff_d  = 1'b0;
          pend_taken_d = 1'b0;
          state_d      = S_DONE;
          unique case (evt_i.payload.req_type)
            qlsa_pkg::REQ_ENQ: begin
              if (wait_ext < lim_ext) begin
                waiting_d = waiting_q + QW'(1);
              end else begin
                pend_drop_d = qlsa_pkg::DROP_QUEUE_FULL;
              end
            end
            qlsa_pkg::REQ_TICK: begin
              // Close the running slot; a missed own slot is penalized first.
              state_d = S_ADV;
              if (in_own_q) begin
                in_own_d = 1'b0;
                if (!ack_seen_q) begin
                  state_d = S_UPD_RD;
                end
              end
            end
            qlsa_pkg::REQ_TX_END: begin
              radio_d = qlsa_pkg::RADIO_WAIT_ACK;
            end
            qlsa_pkg::REQ_RX_START: begin
              if (radio_q == qlsa_pkg::RADIO_WAIT_ACK) begin
                radio_d = qlsa_pkg::RADIO_RX;
              end
            end
            qlsa_pkg::REQ_RX_END: begin
              if (radio_q != qlsa_pkg::RADIO_TX) begin
                radio_d = qlsa_pkg::RADIO_IDLE;
                priority if (evt_i.payload.rx_error) begin
                  pend_drop_d = qlsa_pkg::DROP_CORRUPT;
                end else if (evt_i.payload.rx_dest_addr != node_addr_q) begin
                  pend_drop_d = qlsa_pkg::DROP_NOT_MINE;
                end else if (!evt_i.payload.rx_is_ack) begin
                  pend_drop_d = qlsa_pkg::DROP_NOT_ACK;
                end else if (in_own_q) begin
                  ack_seen_d   = 1'b1;
                  pend_taken_d = 1'b1;
                  state_d      = S_UPD_RD;
                end else begin
                  pend_drop_d = qlsa_pkg::DROP_ACK_OUT;
                end
              end else begin
                pend_drop_d = qlsa_pkg::DROP_BUSY;
              end
            end
            default: ;
          endcase
        end
      end

      S_UPD_RD: begin
        qt_upd_rd = 1'b1;
        state_d   = S_UPD_MUL;
      end

      S_UPD_MUL: begin
        upd_mul = 1'b1;
        state_d = S_UPD_WR;
      end

      S_UPD_WR: begin
        qt_wr_en = 1'b1;
        if (ev_q.req_type == qlsa_pkg::REQ_TICK) begin
          state_d = S_ADV;
          if (backoff_mode_q == qlsa_pkg::BO_ALWAYS) begin
            pend_boff_d = 1'b1;
          end else if (backoff_mode_q == qlsa_pkg::BO_NOT_BEST) begin
            if (slot_idx_q >= n_eff) begin
              pend_boff_d = 1'b1;
            end else begin
              state_d = S_BO_GO;
            end
          end
        end else begin
          state_d = S_DONE;
        end
      end

      S_BO_GO: begin
        scan_cmd.start = 1'b1;
        state_d        = S_BO_WAIT;
      end

      S_BO_WAIT: begin
        if (scan_sts.done) begin
          pend_boff_d = (q_new != scan_max);
          state_d     = S_ADV;
        end
      end

      S_ADV: begin
        radio_d = qlsa_pkg::RADIO_IDLE;
        if (slot_inc >= n_eff) begin
          slot_idx_d   = '0;
          sent_frame_d = 1'b0;
          state_d      = S_PK1_GO;
        end else begin
          slot_idx_d = slot_inc;
          state_d    = S_OWN;
        end
      end

      S_PK1_GO: begin
        scan_cmd.start = 1'b1;
        state_d        = S_PK1_WAIT;
      end

      S_PK1_WAIT: begin
        if (scan_sts.done) begin
          state_d = S_PK_IDX;
        end
      end

      S_PK_IDX: begin
        idx_d   = tie_prod[TW-1:16];
        state_d = S_PK2_GO;
      end

      S_PK2_GO: begin
        scan_cmd.start = 1'b1;
        scan_cmd.find  = 1'b1;
        state_d        = S_PK2_WAIT;
      end

      S_PK2_WAIT: begin
        if (scan_sts.done) begin
          own_slot_d = scan_pos;
          state_d    = S_OWN;
        end
      end

      S_OWN: begin
        // Entering the own slot sends one queued packet, at most one per frame.
        in_own_d   = own_match;
        ack_seen_d = 1'b0;
        if (own_match && (max_per_slot_q != 8'd0) && !sent_frame_q &&
            (waiting_q != '0)) begin
          waiting_d    = waiting_q - QW'(1);
          radio_d      = qlsa_pkg::RADIO_TX;
          sent_frame_d = 1'b1;
          pend_tx_d    = 1'b1;
        end
        state_d = S_DONE;
      end

      S_DONE: begin
        if (res_load) begin
          state_d = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      slot_idx_q   <= '0;
      own_slot_q   <= SW'(1);
      in_own_q     <= 1'b0;
      radio_q      <= qlsa_pkg::RADIO_IDLE;
      ack_seen_q   <= 1'b0;
      sent_frame_q <= 1'b0;
      waiting_q    <= '0;
      res_vld_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      slot_idx_q   <= slot_idx_d;
      own_slot_q   <= own_slot_d;
      in_own_q     <= in_own_d;
      radio_q      <= radio_d;
      ack_seen_q   <= ack_seen_d;
      sent_frame_q <= sent_frame_d;
      waiting_q    <= waiting_d;
      if (res_load) begin
        res_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ev_q         <= ev_d;
    idx_q        <= idx_d;
    pend_tx_q    <= pend_tx_d;
    pend_drop_q  <= pend_drop_d;
    pend_boff_q  <= pend_boff_d;
    pend_taken_q <= pend_taken_d;
    if (res_load) begin
      res_q <= res_next;
    end
  end

  // The result is loaded once the output register is empty or being drained.
  assign res_load = (state_q == S_DONE) && (!res_vld_q || res_o.ready);

  always_comb begin
    res_next.tx_start     = pend_tx_q;
    res_next.drop_code    = pend_drop_q;
    res_next.add_backoff  = pend_boff_q;
    res_next.current_slot = slot_ext[3:0];
    res_next.chosen_slot  = own_ext[3:0];
    res_next.slot_mine    = in_own_q;
    res_next.queue_count  = wait_ext[6:0];
    res_next.ack_taken    = pend_taken_q;
  end

  assign evt_i.ready   = (state_q == S_IDLE);
  assign res_o.valid   = res_vld_q;
  assign res_o.payload = res_q;

  // The update reads the running slot; otherwise the scan owns the read port.
  assign qt_rd_en   = qt_upd_rd || scan_rd_en;
  assign qt_rd_addr = qt_upd_rd ? slot_idx_q[AW-1:0] : scan_addr;

  qlsa_qtab #(
    .SLOTS  (SLOTS),
    .Q_BITS (Q_BITS),
    .AW     (AW)
  ) u_qtab (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (qt_rd_en),
    .rd_addr_i (qt_rd_addr),
    .rdata_o   (qt_rdata),
    .wr_en_i   (qt_wr_en),
    .wr_addr_i (slot_idx_q[AW-1:0]),
    .wdata_i   (q_new)
  );

  qlsa_qupd #(
    .Q_BITS (Q_BITS)
  ) u_qupd (
    .clk_i        (clk_i),
    .mul_en_i     (upd_mul),
    .reward_pos_i (ev_q.req_type == qlsa_pkg::REQ_RX_END),
    .q_i          (qt_rdata),
    .q_new_o      (q_new)
  );

  qlsa_scan #(
    .SLOTS  (SLOTS),
    .Q_BITS (Q_BITS),
    .SW     (SW),
    .AW     (AW)
  ) u_scan (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (scan_cmd),
    .n_i       (n_eff),
    .target_i  (idx_q),
    .rdata_i   (qt_rdata),
    .rd_en_o   (scan_rd_en),
    .rd_addr_o (scan_addr),
    .sts_o     (scan_sts),
    .max_o     (scan_max),
    .ties_o    (scan_ties),
    .pos_o     (scan_pos)
  );

  // The tie index is below the tie count, so the second pass always hits.
  `QLSA_ASSERT(a_pick_hit, (state_q == S_PK2_WAIT && scan_sts.done) |-> scan_sts.hit, "pick pass ended without a hit")
  `QLSA_ASSERT(a_pick_range, (state_q == S_PK2_WAIT && scan_sts.done) |=> (own_slot_q < n_eff), "picked slot outside the frame")
  `QLSA_ASSERT_ALWAYS(a_done_in_wait, scan_sts.done |-> (state_q == S_BO_WAIT || state_q == S_PK1_WAIT || state_q == S_PK2_WAIT), "scan finished outside a wait state")
  `QLSA_ASSERT(a_tx_own_slot, (res_o.valid && res_o.payload.tx_start) |-> (res_o.payload.slot_mine && res_o.payload.drop_code == qlsa_pkg::DROP_NONE), "transfer reports a send outside the own slot")
  `QLSA_ASSERT(a_ack_own_slot, (res_o.valid && res_o.payload.ack_taken) |-> (res_o.payload.slot_mine && res_o.payload.drop_code == qlsa_pkg::DROP_NONE), "ack taken outside the own slot")

endmodule

`default_nettype wire

### rtl/qlsa_qtab.sv
`default_nettype none

module qlsa_qtab #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned Q_BITS = 16,
  parameter int unsigned AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     rd_en_i,
  input  wire logic [AW-1:0]            rd_addr_i,
  output logic signed [Q_BITS-1:0]      rdata_o,
  input  wire logic                     wr_en_i,
  input  wire logic [AW-1:0]            wr_addr_i,
  input  wire logic signed [Q_BITS-1:0] wdata_i
);

  logic [Q_BITS-1:0] mem_q [SLOTS];
  logic [Q_BITS-1:0] rdata_q;
  logic [SLOTS-1:0]  vld_q;
  logic              rvld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wdata_i;
    end
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // An entry never written reads as zero, the reset value of the table.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rvld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rdata_o = rvld_q ? $signed(rdata_q) : '0;

endmodule

`default_nettype wire

### rtl/qlsa_qupd.sv
`default_nettype none

module qlsa_qupd #(
  parameter int unsigned Q_BITS = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     mul_en_i,
  input  wire logic                     reward_pos_i,
  input  wire logic signed [Q_BITS-1:0] q_i,
  output logic signed [Q_BITS-1:0]      q_new_o
);

  localparam int unsigned DW = ((Q_BITS > 16) ? Q_BITS : 16) + 1;
  localparam int unsigned PW = DW + 12;

  localparam logic signed [DW-1:0] OneS   = DW'(qlsa_pkg::Q_ONE);
  localparam logic signed [PW-1:0] AlphaS = PW'(qlsa_pkg::Q_ALPHA);
  localparam logic signed [PW-1:0] QHi    = PW'((64'sd1 <<< (Q_BITS - 1)) - 64'sd1);
  localparam logic signed [PW-1:0] QLo    = -QHi - PW'(1);

  logic signed [DW-1:0]     diff;
  logic signed [PW-1:0]     prod_d;
  logic signed [PW-1:0]     prod_q;
  logic signed [Q_BITS-1:0] qold_q;
  logic signed [PW-1:0]     sum;

  // First step: distance to the reward scaled by the learning rate.
  assign diff   = (reward_pos_i ? OneS : -OneS) - DW'(q_i);
  assign prod_d = PW'(diff) * AlphaS;

  always_ff @(posedge clk_i) begin
    if (mul_en_i) begin
      prod_q <= prod_d;
      qold_q <= q_i;
    end
  end

  // Second step: the arithmetic shift floors, then the sum saturates.
  assign sum = PW'(qold_q) + (prod_q >>> qlsa_pkg::Q_FRAC);

  always_comb begin
    if (sum > QHi) begin
      q_new_o = QHi[Q_BITS-1:0];
    end else if (sum < QLo) begin
      q_new_o = QLo[Q_BITS-1:0];
    end else begin
      q_new_o = sum[Q_BITS-1:0];
    end
  end

endmodule

`default_nettype wire

### rtl/qlsa_scan.sv
`default_nettype none

module qlsa_scan #(
  parameter int unsigned SLOTS  = 16,
  parameter int unsigned Q_BITS = 16,
  parameter int unsigned SW     = $clog2(SLOTS + 1),
  parameter int unsigned AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire qlsa_pkg::scan_cmd_t      cmd_i,
  input  wire logic [SW-1:0]            n_i,
  input  wire logic [SW-1:0]            target_i,
  input  wire logic signed [Q_BITS-1:0] rdata_i,
  output logic                          rd_en_o,
  output logic [AW-1:0]                 rd_addr_o,
  output qlsa_pkg::scan_sts_t           sts_o,
  output logic signed [Q_BITS-1:0]      max_o,
  output logic [SW-1:0]                 ties_o,
  output logic [SW-1:0]                 pos_o
);

  logic                     busy_q, find_q, dv_q, done_q, hit_q;
  logic [SW-1:0]            cnt_q, dpos_q, ties_q, k_q, pos_q;
  logic signed [Q_BITS-1:0] max_q;
  logic                     last;
  logic                     gt, eq;

  // One compare unit serves every pass.
  assign gt      = rdata_i > max_q;
  assign eq      = rdata_i == max_q;
  assign last    = dv_q && (dpos_q == n_i - SW'(1));
  assign rd_en_o = busy_q && (cnt_q < n_i);
  assign rd_addr_o = cnt_q[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      find_q <= 1'b0;
      dv_q   <= 1'b0;
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      dv_q   <= rd_en_o;
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        find_q <= cmd_i.find;
        hit_q  <= 1'b0;
      end else begin
        if (dv_q && find_q && eq && (k_q == target_i)) begin
          hit_q <= 1'b1;
        end
        if (last) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    dpos_q <= cnt_q;
    if (cmd_i.start) begin
      cnt_q <= '0;
      k_q   <= '0;
    end else begin
      if (rd_en_o) begin
        cnt_q <= cnt_q + SW'(1);
      end
      if (dv_q) begin
        if (!find_q) begin
          if ((dpos_q == '0) || gt) begin
            max_q  <= rdata_i;
            ties_q <= SW'(1);
          end else if (eq) begin
            ties_q <= ties_q + SW'(1);
          end
        end else if (eq) begin
          if (k_q == target_i) begin
            pos_q <= dpos_q;
          end
          k_q <= k_q + SW'(1);
        end
      end
    end
  end

  assign sts_o.done = done_q;
  assign sts_o.hit  = hit_q;
  assign max_o      = max_q;
  assign ties_o     = ties_q;
  assign pos_o      = pos_q;

endmodule

`default_nettype wire
